// ===== rtl/irle_pkg.sv =====
package irle_pkg;

    // Default geometry and pixel width
    localparam int DIM_BITS_DEF   = 12;
    localparam int PIXEL_BITS_DEF = 16;

    // Saturating run length counter width
    localparam int LEN_W = 25;

    // Register port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Output queue depth (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Register map, word index taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_COLUMN_COUNT = 2'd1,
        REG_ENCODE_MODE  = 2'd2
    } reg_index_t;

    // Encoding modes
    localparam logic MODE_KEEP_ZEROS = 1'b0;
    localparam logic MODE_SKIP_ZEROS = 1'b1;

endpackage

// ===== rtl/image_run_length_encoder.sv =====
// Run-length encoder for raster-order image pixels. Takes one pixel per cycle on
// pixel_valid/pixel_stall and gives finished runs (start position, value,
// saturating length) on run_valid/run_stall. encode_mode 0 encodes every pixel and
// closes runs at each row end; encode_mode 1 drops zero pixels, lets a zero close
// a run and lets runs continue into the next row. The last pixel of an image
// flushes the open run and flags it with image_end; the position then wraps for
// the next image. run_valid rises once the pixel that ends a run has passed the
// input register into the output queue. The rate is one pixel per cycle while the
// queue has room; a pixel that closes two runs writes both into that four-entry
// queue, which drains one run per cycle while run_stall is low, and pixel_stall
// rises while a pixel waits and the queue holds over two runs. Size registers read
// zero as one and clamp at the full size; write configuration only while idle.
module image_run_length_encoder
    import irle_pkg::*;
#(
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    output logic                  run_valid,
    input  logic                  run_stall,
    output logic [DIM_BITS-1:0]   start_row,
    output logic [DIM_BITS-1:0]   start_column,
    output logic [PIXEL_BITS-1:0] run_value,
    output logic [LEN_W-1:0]      run_length,
    output logic                  image_end,
    output logic                  last_of_item
);

    localparam int RES_W = 2*DIM_BITS + PIXEL_BITS + LEN_W + 2;

    logic [DIM_BITS-1:0] row_last;
    logic [DIM_BITS-1:0] col_last;
    logic                mode;
    logic                room;
    logic                push_one;
    logic                push_two;
    logic [RES_W-1:0]    res_a;
    logic [RES_W-1:0]    res_b;
    logic [RES_W-1:0]    q_dout;

    assign pready = 1'b1;

    // Configuration registers
    irle_regs #(
        .DIM_BITS (DIM_BITS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .row_last (row_last),
        .col_last (col_last),
        .mode     (mode)
    );

    // Run tracking
    irle_core #(
        .DIM_BITS   (DIM_BITS),
        .PIXEL_BITS (PIXEL_BITS),
        .RES_W      (RES_W)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_valid),
        .in_pixel (pixel_value),
        .in_stall (pixel_stall),
        .row_last (row_last),
        .col_last (col_last),
        .mode     (mode),
        .room     (room),
        .push_one (push_one),
        .push_two (push_two),
        .res_a    (res_a),
        .res_b    (res_b)
    );

    // Output queue
    irle_queue #(
        .WIDTH (RES_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_one  (push_one),
        .push_two  (push_two),
        .din0      (res_a),
        .din1      (res_b),
        .room      (room),
        .out_valid (run_valid),
        .out_stall (run_stall),
        .dout      (q_dout)
    );

    assign {start_row, start_column, run_value, run_length, image_end, last_of_item} = q_dout;

endmodule

// ===== rtl/irle_regs.sv =====
module irle_regs
    import irle_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic [DIM_BITS-1:0]   row_last,
    output logic [DIM_BITS-1:0]   col_last,
    output logic                  mode
);

    logic [DIM_BITS:0] row_count_reg, row_count_next;
    logic [DIM_BITS:0] column_count_reg, column_count_next;
    logic              encode_mode_reg, encode_mode_next;
    logic              wr_en;
    reg_index_t        index;

    // Last valid index for a size register: zero counts as one, anything
    // at or above the full size counts as the full size
    function automatic logic [DIM_BITS-1:0] last_of(input logic [DIM_BITS:0] v);
        logic [DIM_BITS:0] dec;
        dec = v - (DIM_BITS+1)'(1);
        if (v == '0)
            return '0;
        else if (v[DIM_BITS])
            return '1;
        else
            return dec[DIM_BITS-1:0];
    endfunction

    assign wr_en = psel && penable && pwrite;
    assign index = reg_index_t'(paddr[3:2]);

    // Register write decode
    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        encode_mode_next  = encode_mode_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_ROW_COUNT:    row_count_next    = pwdata[DIM_BITS:0];
                REG_COLUMN_COUNT: column_count_next = pwdata[DIM_BITS:0];
                REG_ENCODE_MODE:  encode_mode_next  = pwdata[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= (DIM_BITS+1)'(1);
            column_count_reg <= (DIM_BITS+1)'(1);
            encode_mode_reg  <= MODE_KEEP_ZEROS;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            encode_mode_reg  <= encode_mode_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (index)
            REG_ROW_COUNT:    prdata = APB_DATA_W'(row_count_reg);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(column_count_reg);
            REG_ENCODE_MODE:  prdata = APB_DATA_W'(encode_mode_reg);
            default:          prdata = '0;
        endcase
    end

    assign row_last = last_of(row_count_reg);
    assign col_last = last_of(column_count_reg);
    assign mode     = encode_mode_reg;

endmodule

// ===== rtl/irle_core.sv =====
module irle_core
    import irle_pkg::*;
#(
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int RES_W      = 2*DIM_BITS + PIXEL_BITS + LEN_W + 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [PIXEL_BITS-1:0] in_pixel,
    output logic                  in_stall,
    input  logic [DIM_BITS-1:0]   row_last,
    input  logic [DIM_BITS-1:0]   col_last,
    input  logic                  mode,
    input  logic                  room,
    output logic                  push_one,
    output logic                  push_two,
    output logic [RES_W-1:0]      res_a,
    output logic [RES_W-1:0]      res_b
);

    // Input stage
    logic                  pix_valid_reg, pix_valid_next;
    logic [PIXEL_BITS-1:0] pix_reg, pix_next;

    // Position of the pixel in the input stage
    logic [DIM_BITS-1:0]   cur_row_reg, cur_row_next;
    logic [DIM_BITS-1:0]   cur_col_reg, cur_col_next;

    // Open run
    logic                  open_reg, open_next;
    logic [PIXEL_BITS-1:0] open_value_reg, open_value_next;
    logic [LEN_W-1:0]      open_len_reg, open_len_next;
    logic [DIM_BITS-1:0]   open_row_reg, open_row_next;
    logic [DIM_BITS-1:0]   open_col_reg, open_col_next;

    logic advance;
    logic in_ready;
    logic row_end;
    logic img_end;
    logic take;
    logic emit_old;
    logic emit_new;
    logic [RES_W-1:0] res_old;
    logic [RES_W-1:0] res_new;

    assign advance  = pix_valid_reg && room;
    assign in_ready = !pix_valid_reg || advance;
    assign in_stall = !in_ready;

    // Input register
    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        pix_next       = pix_reg;
        if (in_ready)
        begin
            pix_valid_next = in_valid;
            if (in_valid)
                pix_next = in_pixel;
        end
    end

    assign row_end = cur_col_reg >= col_last;
    assign img_end = row_end && (cur_row_reg >= row_last);
    assign take    = (mode == MODE_KEEP_ZEROS) || (pix_reg != '0);

    // Run tracking: the old run may close, a new one may open, and the run
    // left open may close at an image end, or at a row end in keep-zeros mode
    always_comb
    begin
        open_next       = open_reg;
        open_value_next = open_value_reg;
        open_len_next   = open_len_reg;
        open_row_next   = open_row_reg;
        open_col_next   = open_col_reg;
        emit_old        = 1'b0;
        emit_new        = 1'b0;
        if (take)
        begin
            if (open_reg && (pix_reg == open_value_reg))
            begin
                if (open_len_reg != '1)
                    open_len_next = open_len_reg + LEN_W'(1);
            end
            else
            begin
                emit_old        = open_reg;
                open_next       = 1'b1;
                open_value_next = pix_reg;
                open_len_next   = LEN_W'(1);
                open_row_next   = cur_row_reg;
                open_col_next   = cur_col_reg;
            end
        end
        else if (open_reg)
        begin
            emit_old  = 1'b1;
            open_next = 1'b0;
        end
        if (open_next && (((mode == MODE_KEEP_ZEROS) && row_end) || img_end))
        begin
            emit_new  = 1'b1;
            open_next = 1'b0;
        end
        if (!advance)
        begin
            open_next       = open_reg;
            open_value_next = open_value_reg;
            open_len_next   = open_len_reg;
            open_row_next   = open_row_reg;
            open_col_next   = open_col_reg;
        end
    end

    // Next position, wraps at image end
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (advance)
        begin
            if (img_end)
            begin
                cur_row_next = '0;
                cur_col_next = '0;
            end
            else if (row_end)
            begin
                cur_col_next = '0;
                cur_row_next = cur_row_reg + DIM_BITS'(1);
            end
            else
            begin
                cur_col_next = cur_col_reg + DIM_BITS'(1);
            end
        end
    end

    // Result words: {row, column, value, length, image_end, last_of_item}
    assign res_old = {open_row_reg, open_col_reg, open_value_reg, open_len_reg,
                      img_end && !emit_new, !emit_new};
    assign res_new = {open_row_next, open_col_next, open_value_next, open_len_next,
                      img_end, 1'b1};

    // Hand results to the output queue, oldest first
    always_comb
    begin
        push_one = advance && (emit_old ^ emit_new);
        push_two = advance && emit_old && emit_new;
        res_a    = emit_old ? res_old : res_new;
        res_b    = res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg  <= 1'b0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            open_reg       <= 1'b0;
            open_value_reg <= '0;
            open_len_reg   <= '0;
            open_row_reg   <= '0;
            open_col_reg   <= '0;
        end
        else
        begin
            pix_valid_reg  <= pix_valid_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            open_reg       <= open_next;
            open_value_reg <= open_value_next;
            open_len_reg   <= open_len_next;
            open_row_reg   <= open_row_next;
            open_col_reg   <= open_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

endmodule

// ===== rtl/irle_queue.sv =====
module irle_queue
    import irle_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_one,
    input  logic             push_two,
    input  logic [WIDTH-1:0] din0,
    input  logic [WIDTH-1:0] din1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_push;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign pop        = out_valid && !out_stall;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    // Number of entries written this cycle
    always_comb
    begin
        if (push_two)
            n_push = CNT_W'(2);
        else if (push_one)
            n_push = CNT_W'(1);
        else
            n_push = '0;
    end

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push[PTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_one || push_two)
            mem[wr_ptr_reg] <= din0;
        if (push_two)
            mem[wr_ptr_inc] <= din1;
    end

    // Space for a two-result transfer, judged on the registered count only
    assign room      = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign dout      = mem[rd_ptr_reg];

endmodule
